@@ rtl/bpfa_pkg.sv @@
`timescale 1ns / 1ps

package bpfa_pkg;

	localparam int unsigned FRAME_SHIFT = 12;
	localparam int unsigned WORD_BITS = 32;
	localparam logic [31:0] FULL_WORD = 32'hffff_ffff;
	localparam logic [13:0] FRAME_COUNT_RESET = 14'd8192;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE = 2'd1,
		REQ_MARK = 2'd2,
		REQ_TEST = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_FULL = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MODIFY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic frame_in_use;
		status_t status;
	} res_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic rd_in;
		logic rd_scan;
		logic modify;
		logic out_load;
		logic out_src_mod;
		logic clearing;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic req_alloc;
		logic in_range;
		logic hit;
		logic exhausted;
	} dp_sts_t;

endpackage

@@ rtl/bpfa_if.sv @@
`timescale 1ns / 1ps

interface bpfa_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [31:0] page_address;

	modport source (output valid, output req_type, output page_address, input ready);
	modport sink (input valid, input req_type, input page_address, output ready);
endinterface

interface bpfa_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] frame_address;
	logic frame_in_use;
	logic [1:0] status;

	modport source (output valid, output frame_address, output frame_in_use, output status,
		input ready);
	modport sink (input valid, input frame_address, input frame_in_use, input status,
		output ready);
endinterface

interface bpfa_cfg_if;
	logic valid;
	logic ready;
	logic [13:0] frame_count;

	modport source (output valid, output frame_count, input ready);
	modport sink (input valid, input frame_count, output ready);
endinterface

@@ rtl/bpfa_ctrl.sv @@
`timescale 1ns / 1ps

module bpfa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  bpfa_pkg::dp_sts_t     sts,
	output bpfa_pkg::ctrl_cmd_t   cmd
);

	bpfa_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;
	logic req_xfer;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == bpfa_pkg::S_IDLE);
	assign req_xfer = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpfa_pkg::S_CLEAR: begin
				if (sts.clear_done) state_d = bpfa_pkg::S_IDLE;
			end
			bpfa_pkg::S_IDLE: begin
				if (req_xfer) begin
					if (sts.req_alloc) state_d = bpfa_pkg::S_SCAN;
					else if (sts.in_range) state_d = bpfa_pkg::S_MODIFY;
					else state_d = bpfa_pkg::S_DONE;
				end
			end
			bpfa_pkg::S_SCAN: begin
				if (sts.hit) state_d = bpfa_pkg::S_MODIFY;
				else if (sts.exhausted) state_d = bpfa_pkg::S_DONE;
			end
			bpfa_pkg::S_MODIFY: begin
				state_d = slot_free ? bpfa_pkg::S_IDLE : bpfa_pkg::S_DONE;
			end
			bpfa_pkg::S_DONE: begin
				if (slot_free) state_d = bpfa_pkg::S_IDLE;
			end
			default: state_d = bpfa_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			bpfa_pkg::S_CLEAR: begin
				cmd.clearing = 1'b1;
			end
			bpfa_pkg::S_IDLE: begin
				cmd.load = req_xfer;
				cmd.rd_in = req_xfer && !sts.req_alloc && sts.in_range;
			end
			bpfa_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.rd_scan = sts.hit;
			end
			bpfa_pkg::S_MODIFY: begin
				cmd.modify = 1'b1;
				cmd.out_load = slot_free;
				cmd.out_src_mod = 1'b1;
			end
			bpfa_pkg::S_DONE: begin
				cmd.out_load = slot_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/bpfa_datapath.sv @@
`timescale 1ns / 1ps

module bpfa_datapath #(
	parameter int unsigned NUM_FRAMES = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpfa_pkg::ctrl_cmd_t   cmd,
	output bpfa_pkg::dp_sts_t     sts,
	input  logic [1:0]            req_type,
	input  logic [31:0]           page_address,
	input  logic                  cfg_valid,
	input  logic [13:0]           cfg_frame_count,
	output logic [31:0]           frame_address,
	output logic                  frame_in_use,
	output logic [1:0]            status
);

	localparam int unsigned MAP_WORDS = (NUM_FRAMES + 31) / 32;
	localparam int unsigned WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned NCHUNK = (MAP_WORDS + 31) / 32;
	localparam int unsigned CW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam logic [31:0] NumFramesW = 32'(NUM_FRAMES);
	localparam logic [CW-1:0] LastChunk = CW'(NCHUNK - 1);
	localparam logic [WAW-1:0] LastWord = WAW'(MAP_WORDS - 1);

	function automatic logic [4:0] lowest_set(input logic [31:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) idx = 5'(i);
		end
		return idx;
	endfunction

	logic [31:0] mem [MAP_WORDS];
	logic [31:0] rdata_q;

	logic [13:0] frame_count_q;
	logic [MAP_WORDS-1:0] full_q;
	logic [CW-1:0] chunk_q;
	logic [WAW-1:0] clr_q;
	bpfa_pkg::req_t req_q;
	logic [WAW-1:0] word_q;
	logic [4:0] bit_q;
	bpfa_pkg::res_t res_q;
	bpfa_pkg::res_t out_q;

	logic [19:0] frame_in;
	logic [WAW-1:0] word_in;
	logic [31:0] lim_frames;
	logic [26:0] limit_words;
	logic [NCHUNK*32-1:0] full_pad;
	logic [31:0] cand;
	logic [4:0] hit_bit;
	logic [CW+4:0] hit_full;
	logic [WAW-1:0] hit_word;
	logic [26:0] next_start;

	logic [4:0] zero_bit;
	logic [4:0] sel_bit;
	logic [31:0] mask;
	logic [31:0] new_word;
	bpfa_pkg::res_t mod_res;

	logic we;
	logic [WAW-1:0] wa;
	logic [31:0] wd;
	logic re;
	logic [WAW-1:0] ra;

	assign frame_in = page_address[31:bpfa_pkg::FRAME_SHIFT];
	assign word_in = frame_in[WAW+4:5];

	assign lim_frames = ({18'd0, frame_count_q} > NumFramesW) ? NumFramesW
		: {18'd0, frame_count_q};
	assign limit_words = lim_frames[31:5];

	always_comb begin
		full_pad = '1;
		full_pad[MAP_WORDS-1:0] = full_q;
	end

	always_comb begin
		for (int j = 0; j < 32; j++) begin
			cand[j] = !full_pad[{chunk_q, 5'(j)}] && (27'({chunk_q, 5'(j)}) < limit_words);
		end
	end

	assign hit_bit = lowest_set(cand);
	assign hit_full = {chunk_q, hit_bit};
	assign hit_word = hit_full[WAW-1:0];
	assign next_start = 27'({chunk_q, 5'd0}) + 27'd32;

	assign sts.clear_done = (clr_q == LastWord);
	assign sts.req_alloc = (req_type == bpfa_pkg::REQ_ALLOC);
	assign sts.in_range = ({12'd0, frame_in} < NumFramesW);
	assign sts.hit = (cand != '0);
	assign sts.exhausted = (cand == '0) && ((chunk_q == LastChunk) || (next_start >= limit_words));

	assign zero_bit = lowest_set(~rdata_q);
	assign sel_bit = (req_q == bpfa_pkg::REQ_ALLOC) ? zero_bit : bit_q;
	assign mask = 32'd1 << sel_bit;

	always_comb begin
		mod_res.frame_address = '0;
		mod_res.frame_in_use = 1'b0;
		mod_res.status = bpfa_pkg::STAT_OK;
		case (req_q)
			bpfa_pkg::REQ_ALLOC: begin
				new_word = rdata_q | mask;
				mod_res.frame_address = 32'({word_q, zero_bit}) << bpfa_pkg::FRAME_SHIFT;
			end
			bpfa_pkg::REQ_FREE: new_word = rdata_q & ~mask;
			bpfa_pkg::REQ_MARK: new_word = rdata_q | mask;
			bpfa_pkg::REQ_TEST: begin
				new_word = rdata_q;
				mod_res.frame_in_use = rdata_q[bit_q];
			end
			default: new_word = rdata_q;
		endcase
	end

	assign we = cmd.clearing || (cmd.modify && (req_q != bpfa_pkg::REQ_TEST));
	assign wa = cmd.clearing ? clr_q : word_q;
	assign wd = cmd.clearing ? '0 : new_word;
	assign re = cmd.rd_in || cmd.rd_scan;
	assign ra = cmd.rd_scan ? hit_word : word_in;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= bpfa_pkg::FRAME_COUNT_RESET;
			full_q <= '0;
			chunk_q <= '0;
			clr_q <= '0;
		end else begin
			if (cfg_valid) frame_count_q <= cfg_frame_count;
			if (cmd.clearing && !sts.clear_done) clr_q <= clr_q + 1'b1;
			if (cmd.load) chunk_q <= '0;
			else if (cmd.scan && !sts.hit && (chunk_q != LastChunk)) chunk_q <= chunk_q + 1'b1;
			if (cmd.modify && (req_q != bpfa_pkg::REQ_TEST))
				full_q[word_q] <= (new_word == bpfa_pkg::FULL_WORD);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= bpfa_pkg::req_t'(req_type);
			word_q <= word_in;
			bit_q <= frame_in[4:0];
			res_q.frame_address <= '0;
			res_q.frame_in_use <= 1'b0;
			res_q.status <= sts.in_range || sts.req_alloc ? bpfa_pkg::STAT_OK
				: bpfa_pkg::STAT_RANGE;
		end
		if (cmd.scan) begin
			if (sts.hit) word_q <= hit_word;
			else if (sts.exhausted) res_q.status <= bpfa_pkg::STAT_FULL;
		end
		if (cmd.modify) res_q <= mod_res;
		if (cmd.out_load) out_q <= cmd.out_src_mod ? mod_res : res_q;
	end

	assign frame_address = out_q.frame_address;
	assign frame_in_use = out_q.frame_in_use;
	assign status = out_q.status;

endmodule

@@ rtl/bitmap_page_frame_allocator.sv @@
`timescale 1ns / 1ps

// First-fit bitmap allocator for 4 KiB frames, one bit per frame.
// Channels: req (req_type, page_address), rsp (frame_address, frame_in_use,
// status) and cfg (frame_count), each a valid/ready transfer.
// One request is worked at a time. Free, mark and test, also with an
// out-of-range address, load their response into the output register from the
// modify or done state and take no new request until back in idle.
// Allocate steps through one further group of 32 map words at a time in the
// free-word search (at most 7 further groups at the default) before it answers,
// and takes no new request until back in idle; the search reads a per-word
// full flag vector 32 words a cycle, then one map memory read and one write.
// At reset the map memory is cleared one word a cycle, all (NUM_FRAMES+31)/32
// words; req.ready stays low until then. cfg is always ready; the user must
// write it only while the block is idle, which the block does not enforce.
// When the receiver stalls, the response is held in the output register;
// one more request is taken and worked, then waits until the output frees.

module bitmap_page_frame_allocator #(
	parameter int unsigned NUM_FRAMES = 8192
) (
	input  logic           clk,
	input  logic           arst_n,
	bpfa_req_if.sink       req,
	bpfa_rsp_if.source     rsp,
	bpfa_cfg_if.sink       cfg
);

	bpfa_pkg::ctrl_cmd_t cmd;
	bpfa_pkg::dp_sts_t sts;

	assign cfg.ready = 1'b1;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpfa_datapath #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req.req_type),
		.page_address    (req.page_address),
		.cfg_valid       (cfg.valid),
		.cfg_frame_count (cfg.frame_count),
		.frame_address   (rsp.frame_address),
		.frame_in_use    (rsp.frame_in_use),
		.status          (rsp.status)
	);

endmodule

@@ rtl/bpfa_checker.sv @@
`timescale 1ns / 1ps

module bpfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] frame_address,
	input logic        frame_in_use,
	input logic [1:0]  status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(frame_address) && $stable(frame_in_use)
			&& $stable(status))
		else $error("response payload changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != bpfa_pkg::STAT_OK) |-> (frame_address == '0) && !frame_in_use)
		else $error("failed response carries a frame");

	a_test_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && frame_in_use |-> (status == bpfa_pkg::STAT_OK) && (frame_address == '0))
		else $error("in-use flag with address or error");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.frame_address (rsp.frame_address),
	.frame_in_use  (rsp.frame_in_use),
	.status        (rsp.status)
);

@@ test/bitmap_page_frame_allocator_tb.sv @@
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_tb;

	localparam int unsigned MAP_FRAMES = 8192;
	localparam int unsigned MAP_WORDS = MAP_FRAMES / bpfa_pkg::WORD_BITS;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned PHASE_OPS = 185;

	typedef struct {
		bpfa_pkg::req_t kind;
		logic [31:0] addr;
	} frame_op_t;

	logic clk;
	logic arst_n;

	bpfa_req_if req_bus();
	bpfa_rsp_if rsp_bus();
	bpfa_cfg_if cfg_bus();

	bitmap_page_frame_allocator #(
		.NUM_FRAMES(MAP_FRAMES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	logic [31:0] frame_map [MAP_WORDS];
	logic [13:0] frame_limit;
	frame_op_t op_backlog[$];
	bpfa_pkg::res_t expected_replies[$];
	bpfa_pkg::res_t want;
	int unsigned failures = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cfg_plan [10] = '{0, 40, 31, 64, 16383, 100, 8192, 8193, 160, 33};
	int unsigned src_plan [4] = '{0, 71, 0, 22};
	int unsigned snk_plan [4] = '{0, 0, 71, 22};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bpfa_pkg::res_t serve_request(bpfa_pkg::req_t kind, logic [31:0] addr);
		bpfa_pkg::res_t r;
		int unsigned span;
		int unsigned frame;
		r = '0;
		r.status = bpfa_pkg::STAT_OK;
		if (kind == bpfa_pkg::REQ_ALLOC) begin
			span = (frame_limit > MAP_FRAMES) ? MAP_FRAMES : frame_limit;
			for (int w = 0; w < span / bpfa_pkg::WORD_BITS; w++) begin
				if (frame_map[w] != bpfa_pkg::FULL_WORD) begin
					for (int b = 0; b < bpfa_pkg::WORD_BITS; b++) begin
						if (!frame_map[w][b]) begin
							frame_map[w][b] = 1'b1;
							frame = w * bpfa_pkg::WORD_BITS + b;
							r.frame_address = frame << bpfa_pkg::FRAME_SHIFT;
							return r;
						end
					end
				end
			end
			r.status = bpfa_pkg::STAT_FULL;
			return r;
		end
		frame = addr >> bpfa_pkg::FRAME_SHIFT;
		if (frame >= MAP_FRAMES) begin
			r.status = bpfa_pkg::STAT_RANGE;
			return r;
		end
		case (kind)
			bpfa_pkg::REQ_FREE:
				frame_map[frame / bpfa_pkg::WORD_BITS][frame % bpfa_pkg::WORD_BITS] = 1'b0;
			bpfa_pkg::REQ_MARK:
				frame_map[frame / bpfa_pkg::WORD_BITS][frame % bpfa_pkg::WORD_BITS] = 1'b1;
			default: r.frame_in_use =
				frame_map[frame / bpfa_pkg::WORD_BITS][frame % bpfa_pkg::WORD_BITS];
		endcase
		return r;
	endfunction

	function automatic frame_op_t random_op();
		frame_op_t op;
		int unsigned pick;
		int unsigned span;
		int unsigned frame;
		pick = $urandom_range(99);
		if (pick < 40)
			op.kind = bpfa_pkg::REQ_ALLOC;
		else if (pick < 65)
			op.kind = bpfa_pkg::REQ_FREE;
		else if (pick < 80)
			op.kind = bpfa_pkg::REQ_MARK;
		else
			op.kind = bpfa_pkg::REQ_TEST;
		span = (frame_limit > MAP_FRAMES) ? MAP_FRAMES : frame_limit;
		span = span + 40;
		if (span < 64)
			span = 64;
		pick = $urandom_range(99);
		if (pick < 8) begin
			op.addr = $urandom();
		end else begin
			if (pick < 14)
				frame = MAP_FRAMES - 24 + $urandom_range(47);
			else
				frame = $urandom_range(span - 1);
			op.addr = (frame << bpfa_pkg::FRAME_SHIFT) | ($urandom() & 32'hfff);
		end
		return op;
	endfunction

	task automatic push_op(bpfa_pkg::req_t kind, logic [31:0] addr);
		frame_op_t op;
		op.kind = kind;
		op.addr = addr;
		op_backlog.push_back(op);
	endtask

	task automatic drain();
		while (op_backlog.size() != 0 || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_frame_count(logic [13:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.frame_count <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		frame_limit = value;
		@(negedge clk);
	endtask

	// request driver: predict on each transfer, then offer the next pending op
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.req_type <= bpfa_pkg::REQ_ALLOC;
			req_bus.page_address <= '0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				expected_replies.push_back(serve_request(bpfa_pkg::req_t'(req_bus.req_type),
					req_bus.page_address));
				void'(op_backlog.pop_front());
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (op_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					req_bus.valid <= 1'b1;
					req_bus.req_type <= op_backlog[0].kind;
					req_bus.page_address <= op_backlog[0].addr;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and ready generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected transfer frame_address %h frame_in_use %b status %0d",
						$time, rsp_bus.frame_address, rsp_bus.frame_in_use, rsp_bus.status);
					failures++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp_bus.frame_address !== want.frame_address) begin
						$display("%0t: frame_address expected %h actual %h", $time,
							want.frame_address, rsp_bus.frame_address);
						failures++;
					end
					if (rsp_bus.frame_in_use !== want.frame_in_use) begin
						$display("%0t: frame_in_use expected %b actual %b", $time,
							want.frame_in_use, rsp_bus.frame_in_use);
						failures++;
					end
					if (rsp_bus.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp_bus.status);
						failures++;
					end
				end
			end
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_bus.valid = 1'b0;
		req_bus.req_type = bpfa_pkg::REQ_ALLOC;
		req_bus.page_address = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.frame_count = '0;
		arst_n = 1'b0;
		for (int w = 0; w < MAP_WORDS; w++)
			frame_map[w] = '0;
		frame_limit = bpfa_pkg::FRAME_COUNT_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_op(bpfa_pkg::REQ_ALLOC, 32'h0000_0000);
		push_op(bpfa_pkg::REQ_TEST, 32'h0000_0000);
		push_op(bpfa_pkg::REQ_ALLOC, 32'h0000_0000);
		push_op(bpfa_pkg::REQ_FREE, 32'h0000_0fff);
		push_op(bpfa_pkg::REQ_FREE, 32'h0000_0abc);
		push_op(bpfa_pkg::REQ_TEST, 32'h0000_0000);
		push_op(bpfa_pkg::REQ_ALLOC, 32'hffff_ffff);
		push_op(bpfa_pkg::REQ_MARK, 32'h0000_2abc);
		push_op(bpfa_pkg::REQ_MARK, 32'h0000_2000);
		push_op(bpfa_pkg::REQ_ALLOC, 32'h5555_5555);
		push_op(bpfa_pkg::REQ_TEST, 32'h0000_2fff);
		push_op(bpfa_pkg::REQ_TEST, 32'h01ff_f000);
		push_op(bpfa_pkg::REQ_MARK, 32'h01ff_ffff);
		push_op(bpfa_pkg::REQ_TEST, 32'h01ff_f123);
		push_op(bpfa_pkg::REQ_FREE, 32'h01ff_f000);
		push_op(bpfa_pkg::REQ_TEST, 32'h01ff_f000);
		push_op(bpfa_pkg::REQ_TEST, 32'h0200_0000);
		push_op(bpfa_pkg::REQ_FREE, 32'hffff_ffff);
		push_op(bpfa_pkg::REQ_MARK, 32'hffff_f000);
		push_op(bpfa_pkg::REQ_TEST, 32'haaaa_aaaa);
		push_op(bpfa_pkg::REQ_FREE, 32'h0000_1000);
		push_op(bpfa_pkg::REQ_ALLOC, 32'h0000_0000);
		drain();

		for (int p = 0; p < 10; p++) begin
			src_idle_pct = src_plan[p % 4];
			snk_stall_pct = snk_plan[p % 4];
			write_frame_count(14'(cfg_plan[p]));
			repeat (PHASE_OPS)
				op_backlog.push_back(random_op());
			if (p == 4)
				hold_asked++;
			drain();
		end

		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
